[hw/rtl/auto_range_histogram_unit_macros.svh]
// Assertion helpers for the histogram unit checker.
`ifndef AUTO_RANGE_HISTOGRAM_UNIT_MACROS_SVH
`define AUTO_RANGE_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ARH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram unit check failed");

// Next-cycle implication, disabled in reset.
`define ARH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram unit check failed");

`endif

[hw/rtl/arh_pkg.sv]
package arh_pkg;

    localparam int VALUE_W      = 32;
    localparam int CFG_W        = 7;
    localparam int BIN_OUT_W    = 6;
    localparam int TOTAL_OUT_W  = 11;
    localparam int DEF_MAX_VALUES = 1024;
    localparam int DEF_MAX_BINS   = 64;
    localparam int QB_BITS      = 32;
    localparam int STEP_W       = 6;

    localparam logic [CFG_W-1:0] BINS_RESET = 7'd16;

    localparam logic STATUS_BINS      = 1'b0;
    localparam logic STATUS_IDENTICAL = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample;
        logic                      final_sample;
    } item_t;

    typedef struct packed {
        logic                        status;
        logic [BIN_OUT_W-1:0]        bin_number;
        logic signed [VALUE_W-1:0]   bin_low_edge;
        logic signed [VALUE_W-1:0]   bin_high_edge;
        logic [TOTAL_OUT_W-1:0]      bin_total;
        logic [TOTAL_OUT_W-1:0]      largest_total;
        logic                        dropped;
        logic                        final_result;
    } result_t;

endpackage

[hw/rtl/arh_ram.sv]
module arh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[hw/rtl/arh_divider.sv]
// Restoring divider, one quotient bit per cycle; caller bounds the quotient to qbits.
module arh_divider #(
    parameter int DW = 38
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DW-1:0]             num,
    input  logic [arh_pkg::VALUE_W-1:0] den,
    input  logic [arh_pkg::STEP_W-1:0]  qbits,
    output logic                      done,
    output logic [arh_pkg::QB_BITS-1:0] quotient,
    output logic [DW-1:0]             remainder
);
    import arh_pkg::*;

    logic [DW-1:0]      rem_reg, rem_next;
    logic [DW-1:0]      sd_reg, sd_next;
    logic [QB_BITS-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    always_comb
    begin
        rem_next   = rem_reg;
        sd_next    = sd_reg;
        quo_next   = quo_reg;
        steps_next = steps_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = num;
            sd_next    = DW'(den) << (qbits - STEP_W'(1));
            quo_next   = '0;
            steps_next = qbits;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_reg >= sd_reg)
            begin
                rem_next = rem_reg - sd_reg;
                quo_next = {quo_reg[QB_BITS-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QB_BITS-2:0], 1'b0};
            end
            sd_next    = sd_reg >> 1;
            steps_next = steps_reg - STEP_W'(1);
            if (steps_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sd_reg  <= sd_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

[hw/rtl/auto_range_histogram_unit.sv]
// Auto-ranging histogram. Values transfer in one per cycle (start while busy is low) and are
// kept in a value RAM while the minimum and maximum are tracked; the transfer marked
// final_sample starts evaluation and busy stays high until the last result has been shown.
// Results appear for one cycle each with result_valid and cannot be stalled, so the receiver
// must take every one of them. If all values are equal one "identical" result follows the
// final transfer, set up in the check state. Otherwise evaluation consists of a clearing
// sweep of the count RAM, a 32-step division for the bin width, then per value a
// read-multiply-divide-increment sequence dominated by the shared bit-serial divider, then per
// bin a read of the count RAM and the presentation of the result. Values beyond MAX_VALUES are
// discarded and flagged as dropped in every result of that set.
module auto_range_histogram_unit #(
    parameter int MAX_VALUES = arh_pkg::DEF_MAX_VALUES,
    parameter int MAX_BINS   = arh_pkg::DEF_MAX_BINS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  arh_pkg::item_t            item,
    input  logic                      cfg_wr_en,
    input  logic [arh_pkg::CFG_W-1:0] cfg_wr_data,
    output logic                      result_valid,
    output arh_pkg::result_t          result
);
    import arh_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VALUES);
    localparam int CNT_W  = $clog2(MAX_VALUES + 1);
    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int DW     = VALUE_W + BIN_W;

    // Sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_QSTART = 4'd3;
    localparam logic [3:0] S_QWAIT  = 4'd4;
    localparam logic [3:0] S_VRD    = 4'd5;
    localparam logic [3:0] S_OFF    = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_BSTART = 4'd8;
    localparam logic [3:0] S_BWAIT  = 4'd9;
    localparam logic [3:0] S_CRD    = 4'd10;
    localparam logic [3:0] S_CWR    = 4'd11;
    localparam logic [3:0] S_ORD    = 4'd12;
    localparam logic [3:0] S_OEM    = 4'd13;

    logic [3:0]                state_reg, state_next;
    logic [CFG_W-1:0]          bins_reg, bins_next;
    logic signed [VALUE_W-1:0] min_reg, min_next;
    logic signed [VALUE_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic [BIN_W-1:0]          nbm1_reg, nbm1_next;
    logic [VALUE_W-1:0]        range_reg, range_next;
    logic [BIN_W-1:0]          idx_reg, idx_next;      // clear sweep, bin and output index
    logic [ADDR_W-1:0]         j_reg, j_next;
    logic [VALUE_W-1:0]        off_reg, off_next;
    logic [DW-1:0]             prod_reg, prod_next;
    logic [QB_BITS-1:0]        qb_reg, qb_next;
    logic [BIN_W-1:0]          rb_reg, rb_next;
    logic [QB_BITS:0]          qlo_reg, qlo_next;
    logic [BIN_W-1:0]          rlo_reg, rlo_next;
    logic [CNT_W-1:0]          largest_reg, largest_next;
    result_t                   result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    logic                      accept;
    logic                      store_full;
    logic                      v_we;
    logic [ADDR_W-1:0]         v_addr;
    logic [VALUE_W-1:0]        v_rdata;
    logic                      c_we;
    logic [BIN_W-1:0]          c_addr;
    logic [CNT_W-1:0]          c_wdata;
    logic [CNT_W-1:0]          c_rdata;
    logic                      div_start;
    logic [DW-1:0]             div_num;
    logic [VALUE_W-1:0]        div_den;
    logic [STEP_W-1:0]         div_qbits;
    logic                      div_done;
    logic [QB_BITS-1:0]        div_quo;
    logic [DW-1:0]             div_rem;
    logic [BIN_W:0]            rsum;
    logic [QB_BITS:0]          qhi;
    logic [BIN_W-1:0]          rhi;
    logic [CNT_W-1:0]          cnt_inc;

    function automatic logic [VALUE_W-1:0] sat_edge(logic signed [VALUE_W-1:0] base,
                                                   logic [QB_BITS:0] q);
        logic signed [VALUE_W+1:0] sum;
        sum = $signed({{2{base[VALUE_W-1]}}, base}) + $signed({1'b0, q});
        if (sum > $signed((VALUE_W+2)'(32'h7fff_ffff)))
        begin
            return 32'h7fff_ffff;
        end
        return sum[VALUE_W-1:0];
    endfunction

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign store_full = (cnt_reg == CNT_W'(MAX_VALUES));
    assign cnt_inc    = c_rdata + CNT_W'(1);

    arh_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_VALUES)) u_values (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (item.sample),
        .rdata (v_rdata)
    );

    arh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_counts (
        .clk   (clk),
        .we    (c_we),
        .addr  (c_addr),
        .wdata (c_wdata),
        .rdata (c_rdata)
    );

    arh_divider #(.DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .num       (div_num),
        .den       (div_den),
        .qbits     (div_qbits),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Memory ports and divider operands
    always_comb
    begin
        v_we      = accept && !store_full;
        v_addr    = (state_reg == S_IDLE) ? cnt_reg[ADDR_W-1:0] : j_reg;
        c_we      = (state_reg == S_CLEAR) || (state_reg == S_CWR);
        c_addr    = idx_reg;
        c_wdata   = (state_reg == S_CLEAR) ? '0 : cnt_inc;
        div_start = (state_reg == S_QSTART) || (state_reg == S_BSTART);
        if (state_reg == S_QSTART)
        begin
            div_num   = DW'(range_reg);
            div_den   = VALUE_W'(nbm1_reg);
            div_qbits = STEP_W'(QB_BITS);
        end
        else
        begin
            div_num   = prod_reg;
            div_den   = range_reg;
            div_qbits = STEP_W'(BIN_W);
        end
    end

    // Next bin edge: add the whole and fractional bin width, carry the fraction over
    always_comb
    begin
        rsum = {1'b0, rlo_reg} + {1'b0, rb_reg};
        if (rsum >= {1'b0, nbm1_reg})
        begin
            rhi = BIN_W'(rsum - {1'b0, nbm1_reg});
            qhi = qlo_reg + {1'b0, qb_reg} + (QB_BITS+1)'(1);
        end
        else
        begin
            rhi = rsum[BIN_W-1:0];
            qhi = qlo_reg + {1'b0, qb_reg};
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        bins_next         = bins_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        cnt_next          = cnt_reg;
        ovf_next          = ovf_reg;
        nbm1_next         = nbm1_reg;
        range_next        = range_reg;
        idx_next          = idx_reg;
        j_next            = j_reg;
        off_next          = off_reg;
        prod_next         = prod_reg;
        qb_next           = qb_reg;
        rb_next           = rb_reg;
        qlo_next          = qlo_reg;
        rlo_next          = rlo_reg;
        largest_next      = largest_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        if (cfg_wr_en)
        begin
            bins_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            min_next = item.sample;
                            max_next = item.sample;
                        end
                        else
                        begin
                            if (item.sample < min_reg)
                            begin
                                min_next = item.sample;
                            end
                            if (item.sample > max_reg)
                            begin
                                max_next = item.sample;
                            end
                        end
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (item.final_sample)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                // Clamp the bin count into 2..MAX_BINS
                if (bins_reg < CFG_W'(2))
                begin
                    nbm1_next = BIN_W'(1);
                end
                else if (32'(bins_reg) > MAX_BINS)
                begin
                    nbm1_next = BIN_W'(MAX_BINS - 1);
                end
                else
                begin
                    nbm1_next = BIN_W'(bins_reg - CFG_W'(1));
                end
                range_next = max_reg - min_reg;
                idx_next   = '0;
                if (max_reg == min_reg)
                begin
                    // All values identical: one result, drop the set
                    result_next.status        = STATUS_IDENTICAL;
                    result_next.bin_number    = '0;
                    result_next.bin_low_edge  = min_reg;
                    result_next.bin_high_edge = min_reg;
                    result_next.bin_total     = TOTAL_OUT_W'(32'(cnt_reg));
                    result_next.largest_total = TOTAL_OUT_W'(32'(cnt_reg));
                    result_next.dropped       = ovf_reg;
                    result_next.final_result  = 1'b1;
                    result_valid_next         = 1'b1;
                    min_next   = '0;
                    max_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CLEAR;
                end
            end

            S_CLEAR:
            begin
                if (idx_reg == nbm1_reg)
                begin
                    state_next = S_QSTART;
                end
                else
                begin
                    idx_next = idx_reg + BIN_W'(1);
                end
            end

            S_QSTART:
            begin
                state_next = S_QWAIT;
            end

            S_QWAIT:
            begin
                if (div_done)
                begin
                    qb_next      = div_quo;
                    rb_next      = div_rem[BIN_W-1:0];
                    j_next       = '0;
                    largest_next = '0;
                    state_next   = S_VRD;
                end
            end

            S_VRD:
            begin
                state_next = S_OFF;
            end

            S_OFF:
            begin
                off_next   = v_rdata - min_reg;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = DW'(off_reg) * DW'(nbm1_reg);
                state_next = S_BSTART;
            end

            S_BSTART:
            begin
                state_next = S_BWAIT;
            end

            S_BWAIT:
            begin
                if (div_done)
                begin
                    idx_next   = div_quo[BIN_W-1:0];
                    state_next = S_CRD;
                end
            end

            S_CRD:
            begin
                state_next = S_CWR;
            end

            S_CWR:
            begin
                // Count write completes here before the next value is read
                if (cnt_inc > largest_reg)
                begin
                    largest_next = cnt_inc;
                end
                if (CNT_W'(j_reg) + CNT_W'(1) == cnt_reg)
                begin
                    idx_next   = '0;
                    qlo_next   = '0;
                    rlo_next   = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    j_next     = j_reg + ADDR_W'(1);
                    state_next = S_VRD;
                end
            end

            S_ORD:
            begin
                state_next = S_OEM;
            end

            S_OEM:
            begin
                result_next.status        = STATUS_BINS;
                result_next.bin_number    = BIN_OUT_W'(32'(idx_reg));
                result_next.bin_low_edge  = sat_edge(min_reg, qlo_reg);
                result_next.bin_high_edge = sat_edge(min_reg, qhi);
                result_next.bin_total     = TOTAL_OUT_W'(32'(c_rdata));
                result_next.largest_total = TOTAL_OUT_W'(32'(largest_reg));
                result_next.dropped       = ovf_reg;
                result_next.final_result  = (idx_reg == nbm1_reg);
                result_valid_next         = 1'b1;
                qlo_next = qhi;
                rlo_next = rhi;
                if (idx_reg == nbm1_reg)
                begin
                    min_next   = '0;
                    max_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + BIN_W'(1);
                    state_next = S_ORD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bins_reg         <= BINS_RESET;
            min_reg          <= '0;
            max_reg          <= '0;
            cnt_reg          <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bins_reg         <= bins_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            cnt_reg          <= cnt_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nbm1_reg    <= nbm1_next;
        range_reg   <= range_next;
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        off_reg     <= off_next;
        prod_reg    <= prod_next;
        qb_reg      <= qb_next;
        rb_reg      <= rb_next;
        qlo_reg     <= qlo_next;
        rlo_reg     <= rlo_next;
        largest_reg <= largest_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
endmodule

[hw/rtl/arh_checker.sv]
`include "auto_range_histogram_unit_macros.svh"

module arh_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input arh_pkg::item_t   item,
    input logic             result_valid,
    input arh_pkg::result_t result
);
    import arh_pkg::*;

    // A value that does not close the set never produces a result
    `ARH_ASSERT_NEXT(a_no_result_mid_set, start && !busy && !item.final_sample, !result_valid)
    // More results are due after a non-final one, so the unit stays busy
    `ARH_ASSERT_NOW(a_busy_between_results, result_valid && !result.final_result, busy)
    // An identical-values result is always the only one of its run
    `ARH_ASSERT_NOW(a_identical_is_last, result_valid && result.status == STATUS_IDENTICAL,
        result.final_result)
endmodule

bind auto_range_histogram_unit arh_checker u_arh_checker (.*);
